FILE: rtl/core/complex_integer_alu_unit_defines.svh
// assertion macros shared by the complex integer alu top and its divider
`ifndef COMPLEX_INTEGER_ALU_UNIT_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define CIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches reset itself
`define CIA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cia_pkg.sv
// shared widths, operation codes and pipeline side-band type
package cia_pkg;

    localparam int OPW       = 16;
    localparam int PW        = 2 * OPW;
    localparam int NW        = PW + 1;
    localparam int QW        = PW;
    localparam int RW        = 33;
    localparam int ACT_W     = 3;
    localparam int S_TDATA_W = 4 * OPW;
    localparam int M_TDATA_W = ((2 * RW + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4
    } t_action;

    typedef struct packed {
        logic [RW-1:0] re;
        logic [RW-1:0] im;
        logic          is_div;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
    } t_side;

endpackage

FILE: rtl/core/complex_integer_alu_unit.sv
// path: front stages a to d, divider stages, output register; throughput: one
// word per cycle unless stalled; set by the 32-stage restoring divider pipeline
// which runs for every word, results of other operations ride alongside it
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: synchronous active low, clears all valid bits, ready right after reset
`include "complex_integer_alu_unit_defines.svh"
module complex_integer_alu_unit
    import cia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // action
    input  logic [ACT_W-1:0]     i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // res_real, res_imag, zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // div_zero
    output logic                 o_m_axis_tuser
);

    logic          en;
    logic          f_valid, d_valid;
    t_side         f_side, d_side;
    logic [QW-1:0] f_num_re, f_num_im, f_den, q_re, q_im;
    logic [QW:0]   qs_re, qs_im;
    logic [RW-1:0] n_re, n_im;
    logic          n_dz;

    logic          r_o_valid;
    logic [RW-1:0] r_re, r_im;
    logic          r_dz;

    // pipeline advances whenever the output slot is free or being taken
    assign en              = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    cia_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_axis_tvalid),
        .i_action (i_s_axis_tuser),
        .i_a_real (i_s_axis_tdata[OPW-1:0]),
        .i_a_imag (i_s_axis_tdata[2*OPW-1:OPW]),
        .i_b_real (i_s_axis_tdata[3*OPW-1:2*OPW]),
        .i_b_imag (i_s_axis_tdata[4*OPW-1:3*OPW]),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_num_re (f_num_re),
        .o_num_im (f_num_im),
        .o_den    (f_den)
    );

    cia_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_valid),
        .i_side   (f_side),
        .i_num_re (f_num_re),
        .i_num_im (f_num_im),
        .i_den    (f_den),
        .o_valid  (d_valid),
        .o_side   (d_side),
        .o_q_re   (q_re),
        .o_q_im   (q_im)
    );

    assign qs_re = d_side.neg_re ? -{1'b0, q_re} : {1'b0, q_re};
    assign qs_im = d_side.neg_im ? -{1'b0, q_im} : {1'b0, q_im};

    always_comb begin
        n_dz = 1'b0;
        if (d_side.is_div) begin
            n_dz = d_side.dz;
            n_re = d_side.dz ? '0 : RW'(signed'(qs_re));
            n_im = d_side.dz ? '0 : RW'(signed'(qs_im));
        end else begin
            n_re = d_side.re;
            n_im = d_side.im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_re <= n_re;
            r_im <= n_im;
            r_dz <= n_dz;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - 2 * RW){1'b0}}, r_im, r_re};
    assign o_m_axis_tuser  = r_dz;

    `CIA_ASSERT_IMP(a_dz_gives_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "zero divisor word carries nonzero data")
    `CIA_ASSERT_IMP(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output slot")
    `CIA_ASSERT_RST(a_empty_after_reset, !i_rst_n, !o_m_axis_tvalid, "output valid right after reset")

endmodule

FILE: rtl/core/cia_front.sv
// operand capture, products, cross sums and sign/magnitude split
module cia_front
    import cia_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ACT_W-1:0]      i_action,
    input  logic signed [OPW-1:0] i_a_real,
    input  logic signed [OPW-1:0] i_a_imag,
    input  logic signed [OPW-1:0] i_b_real,
    input  logic signed [OPW-1:0] i_b_imag,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [QW-1:0]         o_num_re,
    output logic [QW-1:0]         o_num_im,
    output logic [QW-1:0]         o_den
);

    // stage a: operand registers
    logic                  r_a_v;
    logic [ACT_W-1:0]      r_a_act;
    logic signed [OPW-1:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;

    // stage b: products and simple results
    logic                  r_b_v;
    logic [ACT_W-1:0]      r_b_act;
    logic signed [PW-1:0]  r_b_rr, r_b_ii, r_b_ri, r_b_ir, r_b_sr, r_b_si;
    logic [RW-1:0]         r_b_re, r_b_im;
    logic [RW-1:0]         n_b_re, n_b_im;

    // stage c: combined sums
    logic                  r_c_v;
    logic                  r_c_div;
    logic signed [NW-1:0]  r_c_num_re, r_c_num_im;
    logic [QW-1:0]         r_c_den;
    logic [RW-1:0]         r_c_re, r_c_im;
    logic signed [NW-1:0]  mul_re, mul_im;
    logic [RW-1:0]         n_c_re, n_c_im;

    // stage d: sign and magnitude
    logic                  r_d_v;
    t_side                 r_d_side;
    logic [QW-1:0]         r_d_num_re, r_d_num_im, r_d_den;
    logic [NW-1:0]         abs_re, abs_im;

    logic signed [OPW:0]   add_re, add_im, sub_re, sub_im, conj_im;

    assign add_re  = {r_a_ar[OPW-1], r_a_ar} + {r_a_br[OPW-1], r_a_br};
    assign add_im  = {r_a_ai[OPW-1], r_a_ai} + {r_a_bi[OPW-1], r_a_bi};
    assign sub_re  = {r_a_ar[OPW-1], r_a_ar} - {r_a_br[OPW-1], r_a_br};
    assign sub_im  = {r_a_ai[OPW-1], r_a_ai} - {r_a_bi[OPW-1], r_a_bi};
    assign conj_im = -{r_a_ai[OPW-1], r_a_ai};

    always_comb begin
        n_b_re = '0;
        n_b_im = '0;
        unique case (t_action'(r_a_act))
            ACT_ADD: begin
                n_b_re = RW'(add_re);
                n_b_im = RW'(add_im);
            end
            ACT_SUB: begin
                n_b_re = RW'(sub_re);
                n_b_im = RW'(sub_im);
            end
            ACT_CONJ: begin
                n_b_re = RW'(r_a_ar);
                n_b_im = RW'(conj_im);
            end
            default: begin
                n_b_re = '0;
                n_b_im = '0;
            end
        endcase
    end

    assign mul_re = {r_b_rr[PW-1], r_b_rr} - {r_b_ii[PW-1], r_b_ii};
    assign mul_im = {r_b_ri[PW-1], r_b_ri} + {r_b_ir[PW-1], r_b_ir};

    always_comb begin
        if (t_action'(r_b_act) == ACT_MUL) begin
            n_c_re = RW'(mul_re);
            n_c_im = RW'(mul_im);
        end else begin
            n_c_re = r_b_re;
            n_c_im = r_b_im;
        end
    end

    assign abs_re = r_c_num_re[NW-1] ? NW'(-r_c_num_re) : NW'(r_c_num_re);
    assign abs_im = r_c_num_im[NW-1] ? NW'(-r_c_num_im) : NW'(r_c_num_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_act <= i_action;
            r_a_ar  <= i_a_real;
            r_a_ai  <= i_a_imag;
            r_a_br  <= i_b_real;
            r_a_bi  <= i_b_imag;

            r_b_act <= r_a_act;
            r_b_rr  <= r_a_ar * r_a_br;
            r_b_ii  <= r_a_ai * r_a_bi;
            r_b_ri  <= r_a_ar * r_a_bi;
            r_b_ir  <= r_a_ai * r_a_br;
            r_b_sr  <= r_a_br * r_a_br;
            r_b_si  <= r_a_bi * r_a_bi;
            r_b_re  <= n_b_re;
            r_b_im  <= n_b_im;

            r_c_div    <= (t_action'(r_b_act) == ACT_DIV);
            r_c_num_re <= {r_b_rr[PW-1], r_b_rr} + {r_b_ii[PW-1], r_b_ii};
            r_c_num_im <= {r_b_ir[PW-1], r_b_ir} - {r_b_ri[PW-1], r_b_ri};
            r_c_den    <= $unsigned(r_b_sr) + $unsigned(r_b_si);
            r_c_re     <= n_c_re;
            r_c_im     <= n_c_im;

            r_d_side.re     <= r_c_re;
            r_d_side.im     <= r_c_im;
            r_d_side.is_div <= r_c_div;
            r_d_side.dz     <= (r_c_den == '0);
            r_d_side.neg_re <= r_c_num_re[NW-1];
            r_d_side.neg_im <= r_c_num_im[NW-1];
            // magnitude never exceeds 2^(PW-1), so QW bits hold it
            r_d_num_re      <= abs_re[QW-1:0];
            r_d_num_im      <= abs_im[QW-1:0];
            r_d_den         <= r_c_den;
        end
    end

    assign o_valid  = r_d_v;
    assign o_side   = r_d_side;
    assign o_num_re = r_d_num_re;
    assign o_num_im = r_d_num_im;
    assign o_den    = r_d_den;

endmodule

FILE: rtl/core/cia_div.sv
// pipelined restoring divider, one quotient bit per stage, two lanes
`include "complex_integer_alu_unit_defines.svh"
module cia_div
    import cia_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [QW-1:0] i_num_re,
    input  logic [QW-1:0] i_num_im,
    input  logic [QW-1:0] i_den,
    output logic          o_valid,
    output t_side         o_side,
    output logic [QW-1:0] o_q_re,
    output logic [QW-1:0] o_q_im
);

    logic          r_v      [QW];
    t_side         r_side   [QW];
    logic [QW-1:0] r_rem_re [QW];
    logic [QW-1:0] r_rem_im [QW];
    logic [QW-1:0] r_nq_re  [QW];
    logic [QW-1:0] r_nq_im  [QW];
    logic [QW-1:0] r_den    [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic          s_v;
            t_side         s_side;
            logic [QW-1:0] s_rem_re, s_rem_im, s_nq_re, s_nq_im, s_den;
            logic [QW:0]   diff_re, diff_im;

            if (k == 0) begin : g_first
                assign s_v      = i_valid;
                assign s_side   = i_side;
                assign s_rem_re = '0;
                assign s_rem_im = '0;
                assign s_nq_re  = i_num_re;
                assign s_nq_im  = i_num_im;
                assign s_den    = i_den;
            end else begin : g_next
                assign s_v      = r_v[k-1];
                assign s_side   = r_side[k-1];
                assign s_rem_re = r_rem_re[k-1];
                assign s_rem_im = r_rem_im[k-1];
                assign s_nq_re  = r_nq_re[k-1];
                assign s_nq_im  = r_nq_im[k-1];
                assign s_den    = r_den[k-1];
            end

            // trial subtract of the shifted partial remainder
            assign diff_re = {s_rem_re, s_nq_re[QW-1]} - {1'b0, s_den};
            assign diff_im = {s_rem_im, s_nq_im[QW-1]} - {1'b0, s_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= s_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k]   <= s_side;
                    r_den[k]    <= s_den;
                    r_rem_re[k] <= diff_re[QW] ? {s_rem_re[QW-2:0], s_nq_re[QW-1]}
                                               : diff_re[QW-1:0];
                    r_rem_im[k] <= diff_im[QW] ? {s_rem_im[QW-2:0], s_nq_im[QW-1]}
                                               : diff_im[QW-1:0];
                    r_nq_re[k]  <= {s_nq_re[QW-2:0], ~diff_re[QW]};
                    r_nq_im[k]  <= {s_nq_im[QW-2:0], ~diff_im[QW]};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_q_re  = r_nq_re[QW-1];
    assign o_q_im  = r_nq_im[QW-1];

    `CIA_ASSERT_IMP(a_rem_below_den, r_v[QW-1] && r_den[QW-1] != '0, r_rem_re[QW-1] < r_den[QW-1] && r_rem_im[QW-1] < r_den[QW-1], "divider remainder not below divisor")
    `CIA_ASSERT_IMP(a_dz_tracks_den, r_v[QW-1], r_side[QW-1].dz == (r_den[QW-1] == '0), "zero flag lost track of divisor")
    `CIA_ASSERT_NXT(a_hold_on_stall, !i_en, r_v[QW-1] == $past(r_v[QW-1]), "divider moved while stalled")

endmodule
